### design/ppsf_pkg.sv
// ============================================================================
// ppsf_pkg
// Shared types and constants for the prime pair sum finder.
// ============================================================================
`default_nettype none

package ppsf_pkg;

    localparam int unsigned NUM_WIDTH_DEF = 32;

    // result status codes
    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic       load_num;   // capture number, candidate = 2
        logic       set_v_cand; // test value = candidate
        logic       set_v_pair; // test value = number - candidate
        logic       init_trial; // divisor = 3, square = 9
        logic       start_div;  // clear remainder, bit counter to msb
        logic       div_step;   // one restoring division step
        logic       next_div;   // divisor += 2
        logic       next_cand;  // candidate += 1
        logic       load_out;   // capture result fields
        logic [1:0] status;     // status code for load_out
    } t_ppsf_cmd;

    // datapath -> controller
    typedef struct packed {
        logic num_bad;   // odd or at most two
        logic cand_over; // candidate above number / 2
        logic v_le1;
        logic v_eq2;
        logic v_even;
        logic sq_gt_v;   // divisor squared exceeds test value
        logic div_last;
        logic rem_zero;
    } t_ppsf_stat;

endpackage

`default_nettype wire

### design/ppsf_if.sv
// ============================================================================
// ppsf_num_if / ppsf_res_if
// Valid/ready channels for input numbers and result items.
// ============================================================================
`default_nettype none

interface ppsf_num_if;
    logic        valid;
    logic        ready;
    logic [31:0] number;
    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface ppsf_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [30:0] smaller_prime;
    logic [31:0] larger_prime;
    modport source (output valid, output status, output smaller_prime,
                    output larger_prime, input ready);
    modport sink   (input valid, input status, input smaller_prime,
                    input larger_prime, output ready);
endinterface

`default_nettype wire

### design/ppsf_datapath.sv
// ============================================================================
// ppsf_datapath
// Candidate, trial divisor, serial remainder unit and result registers.
// ============================================================================
`default_nettype none

module ppsf_datapath
    import ppsf_pkg::*;
#(
    parameter int unsigned NUM_WIDTH = NUM_WIDTH_DEF
) (
    input  wire              i_clk,
    input  wire [31:0]       i_number,
    input  var t_ppsf_cmd    i_cmd,
    output t_ppsf_stat       o_stat,
    output logic [1:0]       o_status,
    output logic [30:0]      o_smaller_prime,
    output logic [31:0]      o_larger_prime
);

    localparam int unsigned W  = NUM_WIDTH;
    localparam int unsigned CW = $clog2(W);

    logic [W-1:0]  r_num, r_cand, r_v, r_d, r_rem;
    logic [W:0]    r_sq;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_status;
    logic [30:0]   r_small;
    logic [31:0]   r_large;
    logic [W:0]    n_shift;
    logic [W-1:0]  n_rem;

    // restoring remainder step, one dividend bit per cycle
    always_comb begin
        n_shift = {r_rem, r_v[r_cnt]};
        if (n_shift >= {1'b0, r_d}) begin
            n_rem = W'(n_shift - {1'b0, r_d});
        end else begin
            n_rem = W'(n_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_num) begin
            r_num  <= W'(i_number);
            r_cand <= W'(2);
        end
        if (i_cmd.next_cand) r_cand <= r_cand + W'(1);
        if (i_cmd.set_v_cand) r_v <= r_cand;
        if (i_cmd.set_v_pair) r_v <= r_num - r_cand;
        if (i_cmd.init_trial) begin
            r_d  <= W'(3);
            r_sq <= (W+1)'(9);
        end
        if (i_cmd.next_div) begin
            // (d+2)^2 = d^2 + 4d + 4
            r_d  <= r_d + W'(2);
            r_sq <= r_sq + (W+1)'({r_d, 2'b00}) + (W+1)'(4);
        end
        if (i_cmd.start_div) begin
            r_rem <= '0;
            r_cnt <= CW'(W-1);
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_cnt <= r_cnt - CW'(1);
        end
        if (i_cmd.load_out) begin
            r_status <= i_cmd.status;
            if (i_cmd.status == ST_FOUND) begin
                r_small <= 31'(r_cand);
                r_large <= 32'(r_num - r_cand);
            end else begin
                r_small <= '0;
                r_large <= '0;
            end
        end
    end

    assign o_stat.num_bad   = (r_num <= W'(2)) || r_num[0];
    assign o_stat.cand_over = r_cand > (r_num >> 1);
    assign o_stat.v_le1     = r_v <= W'(1);
    assign o_stat.v_eq2     = r_v == W'(2);
    assign o_stat.v_even    = !r_v[0];
    assign o_stat.sq_gt_v   = r_sq > {1'b0, r_v};
    assign o_stat.div_last  = r_cnt == '0;
    assign o_stat.rem_zero  = r_rem == '0;

    assign o_status        = r_status;
    assign o_smaller_prime = r_small;
    assign o_larger_prime  = r_large;

endmodule

`default_nettype wire

### design/ppsf_ctrl.sv
// ============================================================================
// ppsf_ctrl
// Sequencer for the candidate scan and the trial division tests.
// ============================================================================
`default_nettype none

module ppsf_ctrl
    import ppsf_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire          i_out_ready,
    input  var t_ppsf_stat i_stat,
    output t_ppsf_cmd    o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_CAND  = 9'b000000100,
        S_PRIME = 9'b000001000,
        S_LOOP  = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_MOD   = 9'b001000000,
        S_DONE  = 9'b010000000,
        S_WAIT  = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_pair, n_pair;   // second test of the pair in progress
    logic   r_out_valid, n_out_valid;
    logic   pass, fail;
    logic [1:0] r_res, n_res;

    assign o_in_ready  = r_state == S_IDLE;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_pair      = r_pair;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.status = r_res;
        pass        = 1'b0;
        fail        = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_num = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.num_bad) begin
                    n_res   = ST_INVALID;
                    n_state = S_DONE;
                end else begin
                    n_state = S_CAND;
                end
            end
            S_CAND: begin
                if (i_stat.cand_over) begin
                    n_res   = ST_NONE;
                    n_state = S_DONE;
                end else begin
                    o_cmd.set_v_cand = 1'b1;
                    n_pair  = 1'b0;
                    n_state = S_PRIME;
                end
            end
            S_PRIME: begin
                if (i_stat.v_le1) begin
                    fail = 1'b1;
                end else if (i_stat.v_eq2) begin
                    pass = 1'b1;
                end else if (i_stat.v_even) begin
                    fail = 1'b1;
                end else begin
                    o_cmd.init_trial = 1'b1;
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (i_stat.sq_gt_v) begin
                    pass = 1'b1;
                end else begin
                    o_cmd.start_div = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_MOD;
            end
            S_MOD: begin
                if (i_stat.rem_zero) begin
                    fail = 1'b1;
                end else begin
                    o_cmd.next_div = 1'b1;
                    n_state = S_LOOP;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (pass) begin
            if (r_pair) begin
                n_res   = ST_FOUND;
                n_state = S_DONE;
            end else begin
                o_cmd.set_v_pair = 1'b1;
                n_pair  = 1'b1;
                n_state = S_PRIME;
            end
        end
        if (fail) begin
            o_cmd.next_cand = 1'b1;
            n_state = S_CAND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pair      <= 1'b0;
            r_out_valid <= 1'b0;
            r_res       <= ST_NONE;
        end else begin
            r_state     <= n_state;
            r_pair      <= n_pair;
            r_out_valid <= n_out_valid;
            r_res       <= n_res;
        end
    end

endmodule

`default_nettype wire

### design/prime_pair_sum_finder.sv
// ============================================================================
// prime_pair_sum_finder
// Splits an even number into two primes, smallest first prime, by trial
// division.
// ============================================================================
//
//   channel   dir  payload                                 transfer when
//   i_num     in   number[31:0]                            valid && ready
//   o_res     out  status[1:0], smaller_prime[30:0],       valid && ready
//                  larger_prime[31:0]
//
// Operation: candidates p = 2, 3, ... are scanned up to number/2; each test of
// p and number-p runs trial division by odd divisors up to the square root,
// and every divisor goes through the bit-serial remainder unit, one dividend
// bit at a time. A prime near 2^32 needs about 32768 divisors, so inputs
// near the top of the 32-bit range are the slowest.
// Reset: synchronous, active low; clears the controller and output valid.
// Stalls: one item at a time; a finished result waits in the output
// register and the next number is taken while it waits.
// ============================================================================
`default_nettype none

module prime_pair_sum_finder
    import ppsf_pkg::*;
#(
    parameter int unsigned NUM_WIDTH = NUM_WIDTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ppsf_num_if.sink    i_num,
    ppsf_res_if.source  o_res
);

    t_ppsf_cmd  cmd;
    t_ppsf_stat stat;

    ppsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_num.valid),
        .o_in_ready  (i_num.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ppsf_datapath #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_number        (i_num.number),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_status        (o_res.status),
        .o_smaller_prime (o_res.smaller_prime),
        .o_larger_prime  (o_res.larger_prime)
    );

    // an accepted number keeps the input closed for the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_num.valid && i_num.ready) |=> !i_num.ready)
        else $error("input ready right after a transfer");

    // a found pair always carries a nonzero first prime
    a_found_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status == ST_FOUND) |-> o_res.smaller_prime != '0)
        else $error("found pair with zero prime");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.status == ST_FOUND || o_res.status == ST_NONE ||
                         o_res.status == ST_INVALID))
        else $error("undefined status code");

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for prime_pair_sum_finder. A directed table covers
// invalid inputs, the smallest sums and the largest word; random numbers
// follow. Each result is checked against its typed answer or the model.
// ============================================================================

module tb_top;
    import ppsf_pkg::*;

    typedef struct {
        logic [1:0]  status;
        logic [30:0] smaller_prime;
        logic [31:0] larger_prime;
    } t_pair_res;

    // directed row: known_res set where the answer is typed in
    typedef struct {
        logic [31:0] number;
        bit          known_res;
        t_pair_res   res;
    } t_num_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ppsf_num_if num_if ();
    ppsf_res_if res_if ();

    prime_pair_sum_finder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_num   (num_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    t_pair_res pair_q[$];   // expected results, oldest first
    int        fail_cnt = 0;
    bit        calm = 1'b0; // no idling in the final stretch

    initial begin
        num_if.valid  = 1'b0;
        num_if.number = '0;
        res_if.ready  = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Model: smallest prime p <= n/2 with n - p prime, found by one scan of
    // the candidates, as the block does.
    // ------------------------------------------------------------------------
    function automatic bit is_prime(longint unsigned v);
        longint unsigned d;
        if (v <= 1) return 1'b0;
        if (v == 2) return 1'b1;
        if (v[0] == 1'b0) return 1'b0;
        for (d = 3; d <= v / d; d += 2)
            if (v % d == 0) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_pair_res split_sum(logic [31:0] number);
        t_pair_res       r;
        longint unsigned n;
        longint unsigned p;
        n = number;
        r.status = ST_INVALID;
        r.smaller_prime = '0;
        r.larger_prime = '0;
        if (n <= 2 || n[0]) return r;
        r.status = ST_NONE;
        for (p = 2; p <= n / 2; p++) begin
            if (is_prime(p) && is_prime(n - p)) begin
                r.status = ST_FOUND;
                r.smaller_prime = p[30:0];
                r.larger_prime = 32'(n - p);
                return r;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: drives at negedge, counts a transfer at posedge
    // ------------------------------------------------------------------------
    task automatic send_num(logic [31:0] number, bit known_res, t_pair_res res);
        int gap;
        if (!calm && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 11);
            num_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        num_if.valid  = 1'b1;
        num_if.number = number;
        @(posedge i_clk);
        while (!num_if.ready) @(posedge i_clk);
        pair_q.push_back(known_res ? res : split_sum(number));
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_num();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35) return {$urandom} | 32'd1;              // odd, full width
        if (sel < 40) return 32'($urandom_range(0, 2));        // too small
        if (sel < 82) return 32'($urandom_range(2, 8191)) << 1; // cheap even
        return 32'($urandom_range(8192, 524287)) << 1;        // wider even
    endfunction

    t_num_row num_tab[] = '{
        '{32'd0,          1'b1, '{ST_INVALID, 31'd0, 32'd0}},
        '{32'd1,          1'b1, '{ST_INVALID, 31'd0, 32'd0}},
        '{32'd2,          1'b1, '{ST_INVALID, 31'd0, 32'd0}},
        '{32'd3,          1'b1, '{ST_INVALID, 31'd0, 32'd0}},
        '{32'hFFFF_FFFF,  1'b1, '{ST_INVALID, 31'd0, 32'd0}},
        '{32'hAAAA_AAAB,  1'b1, '{ST_INVALID, 31'd0, 32'd0}},
        '{32'h5555_5555,  1'b1, '{ST_INVALID, 31'd0, 32'd0}},
        '{32'd4,          1'b1, '{ST_FOUND,   31'd2, 32'd2}},
        '{32'd6,          1'b1, '{ST_FOUND,   31'd3, 32'd3}},
        '{32'd8,          1'b1, '{ST_FOUND,   31'd3, 32'd5}},
        '{32'd10,         1'b1, '{ST_FOUND,   31'd3, 32'd7}},
        '{32'd100,        1'b0, '{ST_FOUND,   31'd0, 32'd0}},
        '{32'd34778,      1'b0, '{ST_FOUND,   31'd0, 32'd0}},
        '{32'd34780,      1'b0, '{ST_FOUND,   31'd0, 32'd0}},
        '{32'd1000000,    1'b0, '{ST_FOUND,   31'd0, 32'd0}},
        '{32'hFFFF_FFFE,  1'b0, '{ST_FOUND,   31'd0, 32'd0}}  // largest even word
    };

    initial begin
        t_pair_res none_res;
        none_res = '{ST_NONE, 31'd0, 32'd0};
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (num_tab[i])
            send_num(num_tab[i].number, num_tab[i].known_res, num_tab[i].res);
        num_if.valid = 1'b0;

        // hold off until the block has drained every result
        while (pair_q.size() != 0) @(negedge i_clk);

        for (int k = 0; k < 100; k++) begin
            if (k == 80) calm = 1'b1;
            send_num(rand_num(), 1'b0, none_res);
        end
        num_if.valid = 1'b0;

        while (pair_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: ready stalls in bursts, none once calm
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 11);
                res_if.ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                res_if.ready = 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_pair_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pair_q.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_cnt++;
            end else begin
                want = pair_q.pop_front();
                if (res_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, res_if.status);
                    fail_cnt++;
                end
                if (res_if.smaller_prime !== want.smaller_prime) begin
                    $error("smaller_prime: expected %0d, got %0d",
                           want.smaller_prime, res_if.smaller_prime);
                    fail_cnt++;
                end
                if (res_if.larger_prime !== want.larger_prime) begin
                    $error("larger_prime: expected %0d, got %0d",
                           want.larger_prime, res_if.larger_prime);
                    fail_cnt++;
                end
            end
        end
    end

    // watchdog: stops the run with TB_ERROR if it has not finished by the delay below
    initial begin
        #2_000_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
